[design/vtp_pkg.sv]
// Package for the vertex transform with perspective divide.
// Item types, widths and constants shared by the front, queue, back and checker.
// No dependencies.
package vtp_pkg;

  localparam int WORD          = 32;           // coordinate and matrix entry width
  localparam int FRAC_BITS_DEF = 16;           // default fraction bits
  localparam int PRODW         = 2 * WORD;     // one entry times one coordinate
  localparam int SUMW          = PRODW + 2;    // four terms, signed
  localparam int MAGW          = SUMW - 1;     // magnitude of a row sum
  localparam int CW            = MAGW + WORD;  // divider remainder width
  localparam int NREG          = 8;            // matrix registers
  localparam int REGW          = 64;
  localparam int CFG_IDXW      = 4;
  localparam int ROWS          = 4;
  localparam int COLS          = 4;
  localparam int QDEPTH        = 4;

  localparam logic [WORD-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [WORD-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [WORD-1:0] vert_x;
    logic signed [WORD-1:0] vert_y;
    logic signed [WORD-1:0] vert_z;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD-1:0] proj_x;
    logic signed [WORD-1:0] proj_y;
    logic signed [WORD-1:0] proj_z;
    logic                   w_is_zero;
    logic                   clipped;
  } out_item_t;

  // Row sums of one item, as queued between front and back.
  typedef struct packed {
    logic signed [SUMW-1:0] s0;
    logic signed [SUMW-1:0] s1;
    logic signed [SUMW-1:0] s2;
    logic signed [SUMW-1:0] s3;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[design/vtp_front.sv]
// Front part: matrix registers, input acceptance, products and row sums.
// Depends on vtp_pkg.
module vtp_front #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vtp_pkg::CFG_IDXW-1:0]    cfg_index,
  input  logic [vtp_pkg::REGW-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vtp_pkg::in_item_t               in_item,
  input  vtp_pkg::q_stat_t                q_stat,
  input  logic                            q_pop,
  output logic                            push,
  output vtp_pkg::sums_t                  push_data
);

  localparam int W = vtp_pkg::WORD;
  localparam int SW = vtp_pkg::SUMW;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic [vtp_pkg::REGW-1:0] mat [vtp_pkg::NREG];

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= {{W{1'b0}}, ONE};
      mat[1] <= '0;
      mat[2] <= {ONE, {W{1'b0}}};
      mat[3] <= '0;
      mat[4] <= '0;
      mat[5] <= {{W{1'b0}}, ONE};
      mat[6] <= '0;
      mat[7] <= {ONE, {W{1'b0}}};
    end else if (cfg_we && cfg_index < vtp_pkg::CFG_IDXW'(vtp_pkg::NREG)) begin
      mat[cfg_index[2:0]] <= cfg_data;
    end
  end

  logic signed [W-1:0] ent [vtp_pkg::ROWS][vtp_pkg::COLS];

  always_comb begin
    for (int r = 0; r < vtp_pkg::ROWS; r++) begin
      for (int c = 0; c < vtp_pkg::COLS; c++) begin
        if ((c & 1) != 0) ent[r][c] = mat[3'(r * 2 + (c >> 1))][2*W-1:W];
        else              ent[r][c] = mat[3'(r * 2 + (c >> 1))][W-1:0];
      end
    end
  end

  logic v1, v2, v3, en;
  logic signed [vtp_pkg::PRODW-1:0] p1 [vtp_pkg::ROWS][3];
  logic signed [SW-1:0] bias1 [vtp_pkg::ROWS];
  logic signed [SW-1:0] sa2 [vtp_pkg::ROWS];
  logic signed [SW-1:0] sb2 [vtp_pkg::ROWS];
  logic signed [SW-1:0] sum3 [vtp_pkg::ROWS];

  // stall only when the last stage holds an item the queue cannot take
  assign en       = !(v3 && q_stat.full && !q_pop);
  assign in_ready = en;
  assign push     = v3 && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < vtp_pkg::ROWS; r++) begin
        p1[r][0] <= ent[r][0] * in_item.vert_x;
        p1[r][1] <= ent[r][1] * in_item.vert_y;
        p1[r][2] <= ent[r][2] * in_item.vert_z;
        bias1[r] <= SW'(ent[r][3]) <<< FRAC_BITS;   // times w = 1.0
        sa2[r]   <= SW'(p1[r][0]) + SW'(p1[r][1]);
        sb2[r]   <= SW'(p1[r][2]) + bias1[r];
        sum3[r]  <= sa2[r] + sb2[r];
      end
    end
  end

  assign push_data.s0 = sum3[0];
  assign push_data.s1 = sum3[1];
  assign push_data.s2 = sum3[2];
  assign push_data.s3 = sum3[3];

endmodule

[design/vtp_queue.sv]
// Short FIFO of row sums between the front and back parts.
// Depends on vtp_pkg.
module vtp_queue #(
  parameter int DEPTH = vtp_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vtp_pkg::sums_t   push_data,
  input  logic             pop,
  output vtp_pkg::sums_t   head,
  output vtp_pkg::q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vtp_pkg::sums_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign stat.full  = (count == (AW+1)'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

[design/vtp_back.sv]
// Back part: magnitudes, overflow check, pipelined divide, saturation, output register.
// Depends on vtp_pkg.
module vtp_back #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  vtp_pkg::q_stat_t   q_stat,
  input  vtp_pkg::sums_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output vtp_pkg::out_item_t out_item
);

  localparam int W   = vtp_pkg::WORD;
  localparam int MW  = vtp_pkg::MAGW;
  localparam int CW  = vtp_pkg::CW;
  localparam int SW  = vtp_pkg::SUMW;
  localparam int NST = W;

  logic en;
  assign en    = !out_valid || out_ready;
  assign q_pop = !q_stat.empty && en;

  // stage b0: signs and magnitudes
  logic signed [SW-1:0] s_in [4];
  assign s_in[0] = q_head.s0;
  assign s_in[1] = q_head.s1;
  assign s_in[2] = q_head.s2;
  assign s_in[3] = q_head.s3;

  logic          b0_v, b0_wz;
  logic [MW-1:0] b0_mag [4];
  logic          b0_sn  [4];

  always_ff @(posedge clk) begin
    if (rst) b0_v <= 1'b0;
    else if (en) b0_v <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        b0_sn[r]  <= s_in[r][SW-1];
        b0_mag[r] <= s_in[r][SW-1] ? MW'(-s_in[r]) : MW'(s_in[r]);
      end
      b0_wz <= (s_in[3] == '0);
    end
  end

  // stage b1: scaled numerators and quotient overflow
  logic          b1_v, b1_wz;
  logic [MW-1:0] b1_den;
  logic [CW-1:0] b1_rem [3];
  logic          b1_ovf [3];
  logic          b1_neg [3];
  logic [CW-1:0] num0 [3];
  logic [CW-1:0] den_top;

  always_comb begin
    den_top = CW'(b0_mag[3]) << W;
    for (int r = 0; r < 3; r++) num0[r] = CW'(b0_mag[r]) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) b1_v <= 1'b0;
    else if (en) b1_v <= b0_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        b1_rem[r] <= num0[r];
        b1_ovf[r] <= (num0[r] >= den_top);   // quotient needs more than 32 bits
        b1_neg[r] <= b0_sn[r] ^ b0_sn[3];
      end
      b1_den <= b0_mag[3];
      b1_wz  <= b0_wz;
    end
  end

  // divide stages: stage k settles quotient bit NST-1-k
  logic          d_v   [NST];
  logic          d_wz  [NST];
  logic [MW-1:0] d_den [NST];
  logic [CW-1:0] d_rem [NST][3];
  logic [W-1:0]  d_q   [NST][3];
  logic          d_ovf [NST][3];
  logic          d_neg [NST][3];

  for (genvar k = 0; k < NST; k++) begin : g_div
    localparam int B = NST - 1 - k;
    logic          src_v, src_wz;
    logic [MW-1:0] src_den;
    logic [CW-1:0] src_rem [3];
    logic [W-1:0]  src_q   [3];
    logic          src_ovf [3];
    logic          src_neg [3];
    logic [CW:0]   diff    [3];
    logic [CW-1:0] tshift;

    if (k == 0) begin : g_first
      always_comb begin
        src_v = b1_v; src_wz = b1_wz; src_den = b1_den;
        for (int r = 0; r < 3; r++) begin
          src_rem[r] = b1_rem[r]; src_q[r] = '0;
          src_ovf[r] = b1_ovf[r]; src_neg[r] = b1_neg[r];
        end
      end
    end else begin : g_next
      always_comb begin
        src_v = d_v[k-1]; src_wz = d_wz[k-1]; src_den = d_den[k-1];
        for (int r = 0; r < 3; r++) begin
          src_rem[r] = d_rem[k-1][r]; src_q[r] = d_q[k-1][r];
          src_ovf[r] = d_ovf[k-1][r]; src_neg[r] = d_neg[k-1][r];
        end
      end
    end

    always_comb begin
      tshift = CW'(src_den) << B;
      for (int r = 0; r < 3; r++) diff[r] = {1'b0, src_rem[r]} - {1'b0, tshift};
    end

    always_ff @(posedge clk) begin
      if (rst) d_v[k] <= 1'b0;
      else if (en) d_v[k] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_wz[k]  <= src_wz;
        d_den[k] <= src_den;
        for (int r = 0; r < 3; r++) begin
          d_ovf[k][r] <= src_ovf[r];
          d_neg[k][r] <= src_neg[r];
          if (!diff[r][CW]) begin
            d_rem[k][r]  <= diff[r][CW-1:0];
            d_q[k][r]    <= src_q[r] | (W'(1) << B);
          end else begin
            d_rem[k][r]  <= src_rem[r];
            d_q[k][r]    <= src_q[r];
          end
        end
      end
    end
  end

  // sign and saturation
  logic [W-1:0] res [3];
  logic         clip_r [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (d_neg[NST-1][r]) begin
        if (d_ovf[NST-1][r] || d_q[NST-1][r] > vtp_pkg::SAT_NEG) begin
          res[r] = vtp_pkg::SAT_NEG; clip_r[r] = 1'b1;
        end else begin
          res[r] = -d_q[NST-1][r]; clip_r[r] = 1'b0;
        end
      end else begin
        if (d_ovf[NST-1][r] || d_q[NST-1][r] > vtp_pkg::SAT_POS) begin
          res[r] = vtp_pkg::SAT_POS; clip_r[r] = 1'b1;
        end else begin
          res[r] = d_q[NST-1][r]; clip_r[r] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= d_v[NST-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_wz[NST-1]) begin
        out_item.proj_x    <= '0;
        out_item.proj_y    <= '0;
        out_item.proj_z    <= '0;
        out_item.w_is_zero <= 1'b1;
        out_item.clipped   <= 1'b0;
      end else begin
        out_item.proj_x    <= res[0];
        out_item.proj_y    <= res[1];
        out_item.proj_z    <= res[2];
        out_item.w_is_zero <= 1'b0;
        out_item.clipped   <= clip_r[0] | clip_r[1] | clip_r[2];
      end
    end
  end

endmodule

[design/vertex_transform_perspective_divide.sv]
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
// Depends on vtp_pkg, vtp_front, vtp_queue, vtp_back.

// The block takes one vertex (x, y, z) in signed fixed point with FRAC_BITS
// fraction bits per cycle while in_ready is high, multiplies (x, y, z, 1) by
// the 4x4 matrix held in eight 64-bit registers, divides the x, y and z row
// sums by the w row sum (truncating toward zero) and returns the saturated
// quotients with the w_is_zero and clipped flags. Throughput is one item per
// clock while out_ready stays high. An accepted item passes the product,
// pair-sum and row-sum stages, the queue, two back setup stages, 32 divider
// stages (one quotient bit each) and the output register. The divider stages
// make up most of the pipeline. The matrix resets to identity and may be
// written only while no item is in flight; writes to an index of 8 or more are
// dropped. A stalled output holds the back part; the queue lets the front keep
// accepting items until it fills.
module vertex_transform_perspective_divide #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [vtp_pkg::CFG_IDXW-1:0] cfg_index,
  input  logic [vtp_pkg::REGW-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  vtp_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output vtp_pkg::out_item_t           out_item
);

  vtp_pkg::q_stat_t q_stat;
  vtp_pkg::sums_t   push_data, q_head;
  logic             push, pop;

  // front: config regs and row sums
  vtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_item,
    .q_stat, .q_pop(pop), .push, .push_data
  );

  // decoupling queue
  vtp_queue #(.DEPTH(vtp_pkg::QDEPTH)) u_queue (
    .clk, .rst, .push, .push_data, .pop, .head(q_head), .stat(q_stat)
  );

  // back: divide and saturate
  vtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .q_stat, .q_head, .q_pop(pop),
    .out_valid, .out_ready, .out_item
  );

endmodule

[design/vtp_checker.sv]
// Port-level checker for the vertex transform block, with its bind.
// Depends on vtp_pkg and vertex_transform_perspective_divide.
module vtp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input vtp_pkg::out_item_t out_item
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // zero w gives zero coordinates, no clip
  a_wzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.w_is_zero |->
      out_item.proj_x == '0 && out_item.proj_y == '0 &&
      out_item.proj_z == '0 && !out_item.clipped)
    else $error("zero w item not cleared");

  // clipped means some coordinate sits at a limit
  a_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.clipped |->
      out_item.proj_x == vtp_pkg::SAT_POS || out_item.proj_x == vtp_pkg::SAT_NEG ||
      out_item.proj_y == vtp_pkg::SAT_POS || out_item.proj_y == vtp_pkg::SAT_NEG ||
      out_item.proj_z == vtp_pkg::SAT_POS || out_item.proj_z == vtp_pkg::SAT_NEG)
    else $error("clipped set without a saturated coordinate");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind vertex_transform_perspective_divide vtp_checker u_vtp_checker (
  .clk, .rst, .out_valid, .out_ready, .out_item
);
